>>> hw/rtl/sorted_multiset_table_top_macros.svh
// assertion macros for the sorted multiset table
`ifndef SORTED_MULTISET_TABLE_TOP_MACROS_SVH
`define SORTED_MULTISET_TABLE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smt_pkg.sv
package smt_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LEN_W     = IDX_W + 1;
  localparam int KEY_W_DEF = 32;
  localparam int MULT_W    = 4;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int GRP_SIZE  = 32;
  localparam int NGRP      = DEPTH / GRP_SIZE;
  localparam int GRP_W     = $clog2(GRP_SIZE);
  localparam int NGRP_W    = IDX_W - GRP_W;

  localparam logic [MULT_W-1:0] MAXM_RESET = 4'd4;

  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic             del_en;
    logic [IDX_W-1:0] del_pos;
    logic [LEN_W-1:0] count;
  } cell_ctl_t;

endpackage

>>> hw/rtl/smt_cell.sv
module smt_cell #(
  parameter int KEY_WIDTH = smt_pkg::KEY_W_DEF,
  parameter int IDX       = 0
) (
  input  logic                        clk,
  input  smt_pkg::cell_ctl_t          ctl,
  input  logic signed [KEY_WIDTH-1:0] key,
  input  logic signed [KEY_WIDTH-1:0] prev_entry,
  input  logic                        prev_le,
  input  logic signed [KEY_WIDTH-1:0] next_entry,
  output logic signed [KEY_WIDTH-1:0] entry,
  output logic                        le,
  output logic                        eq
);
  import smt_pkg::*;

  localparam logic [LEN_W-1:0] IDX_LEN = LEN_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_POS = IDX_W'(IDX);

  logic signed [KEY_WIDTH-1:0] entry_r, entry_nxt;
  logic                        le_r, le_nxt;
  logic                        eq_r, eq_nxt;
  logic                        valid;

  assign valid = IDX_LEN < ctl.count;

  always_comb begin
    entry_nxt = entry_r;
    le_nxt    = le_r;
    eq_nxt    = eq_r;
    if (ctl.cmp_en) begin
      le_nxt = valid && (entry_r <= key);
      eq_nxt = valid && (entry_r == key);
    end
    // insert opens one slot at the first entry above the key
    if (ctl.ins_en && !le_r) begin
      entry_nxt = prev_le ? key : prev_entry;
    end else if (ctl.del_en && (IDX_POS >= ctl.del_pos)) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    le_r    <= le_nxt;
    eq_r    <= eq_nxt;
  end

  assign entry = entry_r;
  assign le    = le_r;
  assign eq    = eq_r;

endmodule

>>> hw/rtl/smt_enc.sv
module smt_enc (
  input  logic                           clk,
  input  logic [smt_pkg::DEPTH-1:0]      vec,
  output logic                           hit,
  output logic [smt_pkg::IDX_W-1:0]      idx
);
  import smt_pkg::*;

  logic             grp_hit_r [NGRP];
  logic [GRP_W-1:0] grp_low_r [NGRP];
  logic             grp_hit_nxt [NGRP];
  logic [GRP_W-1:0] grp_low_nxt [NGRP];
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // first level: one-hot to binary inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = |vec[g*GRP_SIZE +: GRP_SIZE];
      grp_low_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (vec[g*GRP_SIZE + j]) begin
          grp_low_nxt[g] = grp_low_nxt[g] | GRP_W'(j);
        end
      end
    end
  end

  // second level: across groups
  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_hit_r[g]) begin
        hit_nxt = 1'b1;
        idx_nxt = idx_nxt | {NGRP_W'(g), grp_low_r[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_r[g] <= grp_hit_nxt[g];
      grp_low_r[g] <= grp_low_nxt[g];
    end
    hit_r <= hit_nxt;
    idx_r <= idx_nxt;
  end

  assign hit = hit_r;
  assign idx = idx_r;

endmodule

>>> hw/rtl/sorted_multiset_table_top.sv
// sorted multiset table: a non-decreasing table of up to 1024 signed keys
// held in a chain of cells, one key per cell, one request at a time.
// input channel: in_valid / in_stall with func (0 locate, 1 insert,
// 2 delete), key, multiplicity and position; a request is taken when
// in_valid is high and in_stall low. in_stall is high while a request
// is being worked on.
// result channel: out_valid / out_stall with located_index, added_count,
// table_length and status; one result per request, held in an output
// register until taken, so the next request may enter while it waits.
// states per request: locate: compare, two encoder levels, calc, done;
// insert: the same, then one shift per copy added; delete: one shift
// (none with the position out of range), then done; unused code: done.
// all cells compare at once, a two-level registered encoder finds the
// interval, and an insert shifts the chain by one slot per cycle.
// a request can enter the cycle after its predecessor's result is loaded.
// config: cfg_valid / cfg_ready with cfg_data writes max_multiplicity;
// cfg_ready is always high. write only while the block is idle.
// reset (rst_n low, synchronous) empties the table, sets
// max_multiplicity to 4 and drops any pending result. a stalled result
// stays in the output register and the block waits before loading another.
module sorted_multiset_table_top #(
  parameter int KEY_WIDTH = smt_pkg::KEY_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smt_pkg::FUNC_W-1:0]    in_func,
  input  logic signed [KEY_WIDTH-1:0]   in_key,
  input  logic [smt_pkg::MULT_W-1:0]    in_multiplicity,
  input  logic [smt_pkg::IDX_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [smt_pkg::LEN_W-1:0] out_located_index,
  output logic [smt_pkg::MULT_W-1:0]    out_added_count,
  output logic [smt_pkg::LEN_W-1:0]     out_table_length,
  output logic [smt_pkg::STAT_W-1:0]    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smt_pkg::MULT_W-1:0]    cfg_data
);
  import smt_pkg::*;

  `include "sorted_multiset_table_top_macros.svh"

  localparam logic [FUNC_W-1:0] FN_LOCATE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [LEN_W-1:0] LOC_NONE = '1;
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMP   = 7'b0000010,
    S_GRP   = 7'b0000100,
    S_ENC   = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [LEN_W-1:0]            count_r, count_nxt;
  logic [MULT_W-1:0]           maxm_r, maxm_nxt;
  logic [MULT_W-1:0]           left_r, left_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [FUNC_W-1:0]           func_r, func_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [MULT_W-1:0]           req_r, req_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic [LEN_W-1:0]            res_loc_r, res_loc_nxt;
  logic [MULT_W-1:0]           res_add_r, res_add_nxt;
  logic [STAT_W-1:0]           res_stat_r, res_stat_nxt;
  logic [LEN_W-1:0]            out_loc_r, out_loc_nxt;
  logic [MULT_W-1:0]           out_add_r, out_add_nxt;
  logic [LEN_W-1:0]            out_len_r, out_len_nxt;
  logic [STAT_W-1:0]           out_stat_r, out_stat_nxt;

  logic                        in_acc;
  logic                        out_load;
  cell_ctl_t                   ctl;

  logic signed [KEY_WIDTH-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]            le_w;
  logic [DEPTH-1:0]            eq_w;
  logic [DEPTH-1:0]            bnd_vec;
  logic [DEPTH-1:0]            first_vec;
  logic                        le_hit, eq_hit;
  logic [IDX_W-1:0]            le_idx, eq_idx;

  logic [LEN_W-1:0]            c_val;
  logic [LEN_W-1:0]            same;
  logic [LEN_W-1:0]            room;
  logic [MULT_W-1:0]           cap;
  logic [MULT_W-1:0]           diff;
  logic [MULT_W-1:0]           mult;
  logic                        trunc;

  // cell chain
  assign ctl.cmp_en  = (state_r == S_CMP);
  assign ctl.ins_en  = (state_r == S_SHIFT) && (func_r == FN_INSERT);
  assign ctl.del_en  = (state_r == S_SHIFT) && (func_r == FN_DELETE);
  assign ctl.del_pos = pos_r;
  assign ctl.count   = count_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] prev_e;
    logic signed [KEY_WIDTH-1:0] next_e;
    logic                        prev_l;
    if (i == 0) begin : g_first
      assign prev_e = key_r;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
      assign prev_l = le_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = entry_w[i];
    end else begin : g_inner
      assign next_e = entry_w[i+1];
    end
    smt_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key_r),
      .prev_entry (prev_e),
      .prev_le    (prev_l),
      .next_entry (next_e),
      .entry      (entry_w[i]),
      .le         (le_w[i]),
      .eq         (eq_w[i])
    );
  end

  // last entry not above the key, first entry equal to it
  assign bnd_vec   = le_w & ~{1'b0, le_w[DEPTH-1:1]};
  assign first_vec = eq_w & ~{eq_w[DEPTH-2:0], 1'b0};

  smt_enc u_enc_le (
    .clk (clk),
    .vec (bnd_vec),
    .hit (le_hit),
    .idx (le_idx)
  );

  smt_enc u_enc_eq (
    .clk (clk),
    .vec (first_vec),
    .hit (eq_hit),
    .idx (eq_idx)
  );

  // insert count
  always_comb begin
    c_val = le_hit ? ({1'b0, le_idx} + LEN_W'(1)) : '0;
    same  = eq_hit ? (c_val - {1'b0, eq_idx}) : '0;
    room  = LEN_MAX - count_r;
    cap   = (req_r < maxm_r) ? req_r : maxm_r;
    diff  = '0;
    mult  = '0;
    trunc = 1'b0;
    if (same < LEN_W'(maxm_r)) begin
      diff = maxm_r - same[MULT_W-1:0];
      mult = (diff < cap) ? diff : cap;
    end
    if (LEN_W'(mult) > room) begin
      mult  = room[MULT_W-1:0];
      trunc = 1'b1;
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    maxm_nxt      = maxm_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    res_loc_nxt   = res_loc_r;
    res_add_nxt   = res_add_r;
    res_stat_nxt  = res_stat_r;
    out_loc_nxt   = out_loc_r;
    out_add_nxt   = out_add_r;
    out_len_nxt   = out_len_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_valid) begin
      maxm_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt     = in_func;
          key_nxt      = in_key;
          req_nxt      = in_multiplicity;
          pos_nxt      = in_position;
          res_loc_nxt  = '0;
          res_add_nxt  = '0;
          res_stat_nxt = ST_OK;
          left_nxt     = MULT_W'(1);
          case (in_func)
            FN_LOCATE: state_nxt = S_CMP;
            FN_INSERT: state_nxt = S_CMP;
            FN_DELETE: begin
              state_nxt = ({1'b0, in_position} < count_r) ? S_SHIFT : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CMP:  state_nxt = S_GRP;
      S_GRP:  state_nxt = S_ENC;
      S_ENC:  state_nxt = S_CALC;
      S_CALC: begin
        if (func_r == FN_LOCATE) begin
          if (count_r == '0) begin
            res_loc_nxt  = LOC_NONE;
            res_stat_nxt = ST_EMPTY;
          end else begin
            res_loc_nxt = le_hit ? {1'b0, le_idx} : LOC_NONE;
          end
          state_nxt = S_DONE;
        end else begin
          res_add_nxt  = mult;
          res_stat_nxt = trunc ? ST_FULL : ST_OK;
          left_nxt     = mult;
          state_nxt    = (mult == '0) ? S_DONE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        count_nxt = (func_r == FN_INSERT) ? (count_r + LEN_W'(1)) : (count_r - LEN_W'(1));
        left_nxt  = left_r - MULT_W'(1);
        if (left_r == MULT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = res_loc_r;
          out_add_nxt   = res_add_r;
          out_len_nxt   = count_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      maxm_r      <= MAXM_RESET;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      maxm_r      <= maxm_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    req_r      <= req_nxt;
    pos_r      <= pos_nxt;
    res_loc_r  <= res_loc_nxt;
    res_add_r  <= res_add_nxt;
    res_stat_r <= res_stat_nxt;
    out_loc_r  <= out_loc_nxt;
    out_add_r  <= out_add_nxt;
    out_len_r  <= out_len_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_located_index = out_loc_r;
  assign out_added_count   = out_add_r;
  assign out_table_length  = out_len_r;
  assign out_status        = out_stat_r;

  `SMT_ASSERT_NEXT(a_req_busy, in_valid && !in_stall, state_r != S_IDLE, "request not started")
  `SMT_ASSERT_NOW(a_count_max, 1'b1, count_r <= LEN_MAX, "table length above depth")
  `SMT_ASSERT_NEXT(a_ins_grow, ctl.ins_en, count_r == $past(count_r) + LEN_W'(1), "insert count")
  `SMT_ASSERT_NOW(a_add_cap, out_valid_r, out_add_r <= maxm_r, "added count above maximum")

endmodule
